>>> src/vslp3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vslp3_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int STAMP_W   = 64;
    localparam int WEIGHT_W  = 16;
    localparam int COUNT_W   = 31;
    localparam int TAU_W     = 40;
    localparam int DT_W      = 40;
    localparam int DEN_W     = DT_W + 1;
    localparam int ALPHA_W   = 16;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int DIV_CNT_W = 4;
    localparam int DIV_STEPS = ALPHA_W;
    localparam int MUL_A_W   = SAMPLE_W + 1;
    localparam int MUL_B_W   = ALPHA_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DT_FRAC   = 12;
    localparam int STEP_LIM  = 52;

    localparam logic [TAU_W-1:0]   TAU_RESET  = TAU_W'(159154943);
    localparam logic [DT_W-1:0]    DT_MAX     = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    localparam int  PADDR_W = 4;
    localparam int  PDATA_W = 64;
    localparam logic REG_TAU = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_WMUL_LO,
        S_WMUL_HI,
        S_DT,
        S_DIVGO,
        S_DIV,
        S_BMUL,
        S_BADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> src/vslp3_div.sv
`timescale 1ns / 1ps
`default_nettype none

module vslp3_div
    import vslp3_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DT_W-1:0]    i_dividend,
    input  wire logic [DEN_W-1:0]   i_divisor,
    output t_div_stat               o_stat,
    output logic [ALPHA_W-1:0]      o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [ALPHA_W-1:0]   r_quo;
    logic [DEN_W:0]       n_twice;
    logic [DEN_W:0]       n_diff;
    logic                 n_ge;

    assign n_twice = {r_rem, 1'b0};
    assign n_diff  = n_twice - {1'b0, r_den};
    assign n_ge    = n_twice >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_twice[DEN_W-1:0];
            r_quo <= {r_quo[ALPHA_W-2:0], n_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_count == '0))
        else $error("divider did not start");

endmodule

`default_nettype wire

>>> src/variable_step_lowpass_3axis_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-axis first-order low-pass filter with a variable time step. Each input transaction
// carries a Q16.16 sample vector, a nanosecond timestamp and a Q4.12 step weight, and yields
// one output transaction with the filtered vector and a saturating sample count. The first
// sample after reset is loaded directly; later samples use the gain dt / (tau + dt), where dt
// is the weighted timestamp difference. The first sample goes from the step state straight to
// the output stage; later samples also pass through the weight multiply, the divide and the
// axis blends. The next input transaction is accepted only once the previous one is done and
// the output register has room: one shared multiplier forms the step and the three axis
// updates over five passes, and the 16-bit gain comes from a radix-2 divider that produces
// one quotient bit per cycle. The input side is ready only while no transaction is in
// progress. The time constant is written through the APB port at address 0 and should only
// change while the block is idle; zero is treated as 1 ns.

module variable_step_lowpass_3axis_unit
    import vslp3_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]              prdata,
    output logic                            pready,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_x,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_y,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_z,
    input  wire logic [STAMP_W-1:0]         i_stamp_ns,
    input  wire logic [WEIGHT_W-1:0]        i_weight,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0]      o_filtered_x,
    output logic signed [SAMPLE_W-1:0]      o_filtered_y,
    output logic signed [SAMPLE_W-1:0]      o_filtered_z,
    output logic [COUNT_W-1:0]              o_sample_count
);

    t_state r_state;
    t_state n_state;

    logic [TAU_W-1:0]          r_tau;
    logic signed [SAMPLE_W-1:0] r_held [AXES];
    logic signed [SAMPLE_W-1:0] r_smp  [AXES];
    logic [STAMP_W-1:0]        r_prev_stamp;
    logic [STAMP_W-1:0]        r_stamp;
    logic [STAMP_W-1:0]        r_diff;
    logic [WEIGHT_W-1:0]       r_weight;
    logic [COUNT_W-1:0]        r_samples_seen;
    logic                      r_first;
    logic signed [PROD_W-1:0]  r_prod;
    logic [STEP_LIM-5:0]       r_prod_lo;
    logic [DT_W-1:0]           r_dt;
    logic [ALPHA_W-1:0]        r_alpha;
    logic [AXIS_W-1:0]         r_axis;
    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_x;
    logic signed [SAMPLE_W-1:0] r_out_y;
    logic signed [SAMPLE_W-1:0] r_out_z;
    logic [COUNT_W-1:0]        r_out_count;

    logic                      cfg_wr;
    logic                      in_accept;
    logic                      div_start;
    logic                      out_load;
    logic                      last_axis;
    t_div_stat                 div_stat;
    logic [ALPHA_W-1:0]        div_quo;
    logic [TAU_W-1:0]          tau_eff;
    logic [DEN_W-1:0]          div_den;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [STAMP_W+4:0]        step_total;
    logic                      step_sat;
    logic [DT_W-1:0]           step_dt;
    logic signed [PROD_W-1:0]  blend_sum;
    logic signed [PROD_W-1:0]  blend_delta;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_TAU);

    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_TAU) begin
            prdata = PDATA_W'(r_tau);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= TAU_RESET;
        end else if (cfg_wr) begin
            r_tau <= pwdata[TAU_W-1:0];
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = (r_samples_seen == '0) ? S_DONE : S_WMUL_LO;
            end
            S_WMUL_LO: n_state = S_WMUL_HI;
            S_WMUL_HI: n_state = S_DT;
            S_DT:      n_state = S_DIVGO;
            S_DIVGO:   n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_BMUL;
                end
            end
            S_BMUL:    n_state = S_BADD;
            S_BADD: begin
                n_state = last_axis ? S_DONE : S_BMUL;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer: control outputs.
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_DIVGO: div_start  = 1'b1;
            S_DONE:  out_load   = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_accept = i_in_valid && o_in_ready;
    assign last_axis = (r_axis == AXIS_W'(AXES - 1));

    // Shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_WMUL_LO: begin
                mul_a = MUL_A_W'(r_diff[31:0]);
                mul_b = MUL_B_W'(r_weight);
            end
            S_WMUL_HI: begin
                mul_a = MUL_A_W'(r_diff[STEP_LIM-1:32]);
                mul_b = MUL_B_W'(r_weight);
            end
            S_BMUL: begin
                mul_a = {r_smp[r_axis][SAMPLE_W-1], r_smp[r_axis]}
                      - {r_held[r_axis][SAMPLE_W-1], r_held[r_axis]};
                mul_b = MUL_B_W'(r_alpha);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Weighted step with saturation. A zero weight gives a zero step for any gap.
    assign step_total = {1'b0, r_prod[35:0], 32'd0} + (STAMP_W + 5)'(r_prod_lo);
    assign step_sat   = (r_weight != '0)
                     && ((r_diff[STAMP_W-1:STEP_LIM] != '0)
                     || (step_total[STAMP_W+4:STEP_LIM] != '0));
    assign step_dt    = step_sat ? DT_MAX : step_total[STEP_LIM-1:DT_FRAC];

    assign tau_eff = (r_tau == '0) ? TAU_W'(1) : r_tau;
    assign div_den = {1'b0, tau_eff} + {1'b0, r_dt};

    vslp3_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dt),
        .i_divisor  (div_den),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign blend_sum   = r_prod + ROUND_HALF;
    assign blend_delta = blend_sum >>> 16;

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0]      <= '0;
            r_held[1]      <= '0;
            r_held[2]      <= '0;
            r_prev_stamp   <= '0;
            r_samples_seen <= '0;
        end else begin
            case (r_state)
                S_STEP: begin
                    r_prev_stamp <= r_stamp;
                    if (r_samples_seen != COUNT_MAX) begin
                        r_samples_seen <= r_samples_seen + 1'b1;
                    end
                    if (r_samples_seen == '0) begin
                        r_held[0] <= r_smp[0];
                        r_held[1] <= r_smp[1];
                        r_held[2] <= r_smp[2];
                    end
                end
                S_BADD: begin
                    r_held[r_axis] <= r_held[r_axis] + blend_delta[SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_smp[0] <= i_sample_x;
            r_smp[1] <= i_sample_y;
            r_smp[2] <= i_sample_z;
            r_stamp  <= i_stamp_ns;
            r_weight <= i_weight;
        end
        case (r_state)
            S_STEP: begin
                r_diff  <= r_stamp - r_prev_stamp;
                r_first <= (r_samples_seen == '0);
            end
            S_WMUL_LO, S_BMUL: begin
                r_prod <= mul_p;
            end
            S_WMUL_HI: begin
                r_prod_lo <= r_prod[STEP_LIM-5:0];
                r_prod    <= mul_p;
            end
            S_DT: begin
                r_dt <= step_dt;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_alpha <= div_quo;
                    r_axis  <= '0;
                end
            end
            S_BADD: begin
                r_axis <= r_axis + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x     <= r_held[0];
            r_out_y     <= r_held[1];
            r_out_z     <= r_held[2];
            r_out_count <= r_samples_seen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_filtered_x   = r_out_x;
    assign o_filtered_y   = r_out_y;
    assign o_filtered_z   = r_out_z;
    assign o_sample_count = r_out_count;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_first_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_samples_seen == '0) |=> (r_state == S_DONE))
        else $error("first sample did not bypass the filter");

    a_count_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_samples_seen != '0) |=> (r_samples_seen != '0))
        else $error("sample count returned to zero");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BMUL || r_state == S_BADD) |-> (r_axis <= AXIS_W'(AXES - 1)))
        else $error("axis index out of range");

    a_first_alpha_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WMUL_LO) |-> !r_first)
        else $error("filter path taken for the first sample");

endmodule

`default_nettype wire
